@@ rtl/core/scrt_pkg.sv @@
package scrt_pkg;

	// Table geometry and field widths.
	localparam int TABLE_DEPTH  = 2048;
	localparam int ADDR_WIDTH   = 32;
	localparam int IDX_W        = $clog2(TABLE_DEPTH);
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
	localparam int SIZE_W       = 32;
	localparam int FIELD_ADDR_W = 32;
	localparam int OUT_IDX_W    = 11;
	localparam int TOTAL_W      = 43;
	localparam int DIFF_W       = (ADDR_WIDTH > SIZE_W) ? ADDR_WIDTH : SIZE_W;

	typedef logic [ADDR_WIDTH-1:0] addr_t;
	typedef logic [SIZE_W-1:0]     size_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_TOTAL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// One table entry as it is held in the memory.
	typedef struct packed {
		addr_t base;
		size_t size;
		logic  free;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Table memory access: write and read address.
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		idx_t   raddr;
	} ram_req_t;

	// One result word.
	typedef struct packed {
		logic                    hit;
		logic [OUT_IDX_W-1:0]    entry_index;
		logic [FIELD_ADDR_W-1:0] found_base;
		size_t                   found_size;
		status_t                 status;
		logic [TOTAL_W-1:0]      used_total;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LK_BASE0,
		S_LK_PROBE,
		S_LK_FINAL,
		S_INS_SCAN,
		S_INS_PUT,
		S_REM_SCAN,
		S_REM_SHIFT,
		S_TOT,
		S_DONE
	} state_t;

endpackage

@@ rtl/core/scrt_ifs.sv @@
interface scrt_in_if;
	import scrt_pkg::*;

	logic                    valid;
	logic                    ready;
	op_t                     op;
	logic [FIELD_ADDR_W-1:0] address;
	size_t                   chunk_size;
	logic                    chunk_free;

	modport source (output valid, op, address, chunk_size, chunk_free, input ready);
	modport sink   (input valid, op, address, chunk_size, chunk_free, output ready);
endinterface

interface scrt_out_if;
	import scrt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    hit;
	logic [OUT_IDX_W-1:0]    entry_index;
	logic [FIELD_ADDR_W-1:0] found_base;
	size_t                   found_size;
	status_t                 status;
	logic [TOTAL_W-1:0]      used_total;

	modport source (output valid, hit, entry_index, found_base, found_size, status,
		used_total, input ready);
	modport sink   (input valid, hit, entry_index, found_base, found_size, status,
		used_total, output ready);
endinterface

interface scrt_cfg_if;
	import scrt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [FIELD_ADDR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/scrt_ram.sv @@
module scrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/scrt_ctrl.sv @@
module scrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	scrt_in_if.sink           req,
	input  scrt_pkg::addr_t   tail_limit,
	output scrt_pkg::ram_req_t ram_req,
	input  scrt_pkg::entry_t  ram_rdata,
	output logic              res_valid,
	output scrt_pkg::res_t    res,
	input  logic              res_take,
	output scrt_pkg::cnt_t    entry_count
);
	import scrt_pkg::*;

	state_t  state_q, state_d;
	cnt_t    cnt_q, cnt_d;
	addr_t   addr_q, addr_d;
	size_t   size_q, size_d;
	logic    free_q, free_d;
	idx_t    ptr_q, ptr_d;
	idx_t    lo_q, lo_d;
	idx_t    hi_q, hi_d;
	idx_t    mid_q, mid_d;
	res_t    res_q, res_d;

	idx_t             nlo, nhi, mid_c;
	logic [IDX_W:0]   lh_sum;
	addr_t            diff;
	logic             hit_c;
	entry_t           new_q, new_in;

	assign new_q  = '{base: addr_q, size: size_q, free: free_q};
	assign new_in = '{base: ADDR_WIDTH'(req.address), size: req.chunk_size,
		free: req.chunk_free};

	// Next search bounds of the binary search and its midpoint.
	always_comb begin
		nlo = lo_q;
		nhi = hi_q;
		if (state_q == S_LK_PROBE) begin
			if (addr_q <= ram_rdata.base) begin
				nhi = mid_q;
			end else begin
				nlo = mid_q + IDX_W'(1);
			end
		end
		lh_sum = {1'b0, nlo} + {1'b0, nhi};
		mid_c  = lh_sum[IDX_W:1];
	end

	assign diff  = addr_q - ram_rdata.base;
	assign hit_c = (addr_q >= ram_rdata.base) &&
		(DIFF_W'(diff) < DIFF_W'(ram_rdata.size)) && !ram_rdata.free;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		addr_d  = addr_q;
		size_d  = size_q;
		free_d  = free_q;
		ptr_d   = ptr_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		res_d   = res_q;
		ram_req = '0;
		req.ready = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					addr_d = ADDR_WIDTH'(req.address);
					size_d = req.chunk_size;
					free_d = req.chunk_free;
					res_d  = '0;
					unique case (req.op)
						OP_LOOKUP: begin
							lo_d = '0;
							hi_d = IDX_W'(cnt_q - CNT_W'(1));
							if (cnt_q == '0) begin
								state_d = S_DONE;
							end else begin
								ram_req.raddr = '0;
								state_d = S_LK_BASE0;
							end
						end
						OP_INSERT: begin
							if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
								res_d.status = ST_FULL;
								state_d = S_DONE;
							end else if (cnt_q == '0) begin
								ram_req.we    = 1'b1;
								ram_req.waddr = '0;
								ram_req.wdata = new_in;
								cnt_d = CNT_W'(1);
								state_d = S_DONE;
							end else begin
								ptr_d = IDX_W'(cnt_q);
								ram_req.raddr = IDX_W'(cnt_q - CNT_W'(1));
								state_d = S_INS_SCAN;
							end
						end
						OP_REMOVE: begin
							if (cnt_q == '0) begin
								res_d.status = ST_NOT_FOUND;
								state_d = S_DONE;
							end else begin
								ptr_d = IDX_W'(cnt_q - CNT_W'(1));
								ram_req.raddr = IDX_W'(cnt_q - CNT_W'(1));
								state_d = S_REM_SCAN;
							end
						end
						OP_TOTAL: begin
							if (cnt_q == '0) begin
								state_d = S_DONE;
							end else begin
								ptr_d = '0;
								ram_req.raddr = '0;
								state_d = S_TOT;
							end
						end
					endcase
				end
			end

			S_LK_BASE0, S_LK_PROBE: begin
				if (state_q == S_LK_BASE0 &&
					!(addr_q > ram_rdata.base && addr_q <= tail_limit)) begin
					state_d = S_DONE;
				end else begin
					lo_d = nlo;
					hi_d = nhi;
					if (nhi > nlo) begin
						mid_d = mid_c;
						ram_req.raddr = mid_c + IDX_W'(1);
						state_d = S_LK_PROBE;
					end else begin
						ram_req.raddr = nhi;
						state_d = S_LK_FINAL;
					end
				end
			end

			S_LK_FINAL: begin
				if (hit_c) begin
					res_d.hit         = 1'b1;
					res_d.entry_index = OUT_IDX_W'(hi_q);
					res_d.found_base  = FIELD_ADDR_W'(ram_rdata.base);
					res_d.found_size  = ram_rdata.size;
				end
				state_d = S_DONE;
			end

			S_INS_SCAN: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = ptr_q;
				if (ram_rdata.base > addr_q) begin
					ram_req.wdata = ram_rdata;
					ptr_d = ptr_q - IDX_W'(1);
					if (ptr_q == IDX_W'(1)) begin
						state_d = S_INS_PUT;
					end else begin
						ram_req.raddr = ptr_q - IDX_W'(2);
					end
				end else begin
					ram_req.wdata = new_q;
					cnt_d = cnt_q + CNT_W'(1);
					res_d.entry_index = OUT_IDX_W'(ptr_q);
					state_d = S_DONE;
				end
			end

			S_INS_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = ptr_q;
				ram_req.wdata = new_q;
				cnt_d = cnt_q + CNT_W'(1);
				res_d.entry_index = OUT_IDX_W'(ptr_q);
				state_d = S_DONE;
			end

			S_REM_SCAN: begin
				if (ram_rdata.base == addr_q) begin
					res_d.entry_index = OUT_IDX_W'(ptr_q);
					if (CNT_W'(ptr_q) + CNT_W'(1) < cnt_q) begin
						ram_req.raddr = ptr_q + IDX_W'(1);
						state_d = S_REM_SHIFT;
					end else begin
						cnt_d = cnt_q - CNT_W'(1);
						state_d = S_DONE;
					end
				end else if (ptr_q == '0) begin
					res_d.status = ST_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					ptr_d = ptr_q - IDX_W'(1);
					ram_req.raddr = ptr_q - IDX_W'(1);
				end
			end

			S_REM_SHIFT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = ptr_q;
				ram_req.wdata = ram_rdata;
				ptr_d = ptr_q + IDX_W'(1);
				if (CNT_W'(ptr_q) + CNT_W'(2) < cnt_q) begin
					ram_req.raddr = ptr_q + IDX_W'(2);
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
					state_d = S_DONE;
				end
			end

			S_TOT: begin
				res_d.used_total = res_q.used_total +
					(ram_rdata.free ? '0 : TOTAL_W'(ram_rdata.size));
				if (CNT_W'(ptr_q) + CNT_W'(1) < cnt_q) begin
					ptr_d = ptr_q + IDX_W'(1);
					ram_req.raddr = ptr_q + IDX_W'(1);
				end else begin
					state_d = S_DONE;
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		size_q <= size_d;
		free_q <= free_d;
		ptr_q  <= ptr_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
		res_q  <= res_d;
	end

	assign res         = res_q;
	assign entry_count = cnt_q;

endmodule

@@ rtl/core/sorted_chunk_range_table_core.sv @@
// Steps to the result word: a lookup checks the first base, then makes P binary-search probes
// (about log2 of the entry count) and a final compare; an insert moves S entries up, a remove
// compares R entries from the top and moves M down, a total reads all N entries; an empty or
// full table, or a lookup outside the first base and the limit, ends sooner. One word is worked
// on at a time, as the table memory has a single read port; the next word is taken in the cycle
// after the result moves on. Reset clears the state, entry count, output valid and tail_limit only.
module sorted_chunk_range_table_core (
	input  logic      clk,
	input  logic      arst_n,
	scrt_in_if.sink   req,
	scrt_out_if.source rsp,
	scrt_cfg_if.sink  cfg
);
	import scrt_pkg::*;

	// The configuration register. Software must write it only while the block is idle; the block
	// does not enforce this itself, and cfg.ready is tied high.
	addr_t tail_limit_q;

	// Table memory. Base, size and free flag of one entry sit side by side in one word, so a
	// single read fetches a whole entry and a single write moves it.
	ram_req_t ram_req;
	entry_t   ram_rdata;

	// The sequencer hands finished results to the output register below.
	logic     res_valid;
	logic     res_take;
	res_t     res;
	cnt_t     entry_count;

	// Output register: it holds a finished word while the sink stalls, so that the sequencer
	// is free to take the next request.
	logic     out_valid_q;
	res_t     out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_limit_q <= '0;
		end else if (cfg.valid) begin
			tail_limit_q <= ADDR_WIDTH'(cfg.data);
		end
	end

	// The sequencer never uses a read of the entry it writes in the same cycle: an insert writes
	// the slot above the one it reads next, a remove the slot below, so no forwarding
	// path is needed around the memory.
	scrt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	scrt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.tail_limit  (tail_limit_q),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take),
		.entry_count (entry_count)
	);

	// A new word may enter the output register when it is empty or is being emptied now.
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_q.hit;
	assign rsp.entry_index = out_q.entry_index;
	assign rsp.found_base  = out_q.found_base;
	assign rsp.found_size  = out_q.found_size;
	assign rsp.status      = out_q.status;
	assign rsp.used_total  = out_q.used_total;

	// The table never holds more entries than the memory has rows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	// An operation adds or removes at most one entry.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(entry_count) |->
			(entry_count == $past(entry_count) + CNT_W'(1)) ||
			(entry_count == $past(entry_count) - CNT_W'(1)))
		else $error("entry count moved by more than one");

	// A request is never taken while a finished result waits in the sequencer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !res_valid)
		else $error("request accepted while a result is pending");

	// A result handed over appears on the output in the next cycle.
	a_handover: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> rsp.valid)
		else $error("handed-over result did not reach the output");

endmodule

@@ tb/sv/tb_sorted_chunk_range_table_core.sv @@
module tb_sorted_chunk_range_table_core;
	import scrt_pkg::*;

	// Cycles without any accepted word before the run is given up. The slowest
	// legitimate pause is a total over a full table plus the longest idle gap
	// on either side, so this leaves a wide margin.
	localparam int STALL_LIMIT = 12000;

	// Cycles left after the last reply so that a stray extra word still shows.
	localparam int DRAIN_CYCLES = 16;

	// Mirror of the chunk table. It works out the reply to every accepted
	// request word and holds the replies still to come, oldest first.
	class chunk_table_board;
		addr_t       base_tab [TABLE_DEPTH];
		size_t       size_tab [TABLE_DEPTH];
		logic        free_tab [TABLE_DEPTH];
		int unsigned entries;
		addr_t       tail_limit;
		res_t        awaited_replies [$];
		int          errors;

		function new();
			entries    = 0;
			tail_limit = '0;
			errors     = 0;
		endfunction

		function void set_tail_limit(addr_t value);
			tail_limit = value;
		endfunction

		// Applies one operation to the mirror and returns the reply it gives.
		function res_t apply_table_op(op_t op, addr_t address, size_t chunk_size,
				logic chunk_free);
			res_t                reply;
			int unsigned         lo;
			int unsigned         hi;
			int unsigned         mid;
			int unsigned         pos;
			int                  idx;
			logic [TOTAL_W-1:0]  sum;

			reply = '0;
			case (op)
				OP_LOOKUP: begin
					if (entries != 0 && address > base_tab[0] && address <= tail_limit) begin
						lo = 0;
						hi = entries - 1;
						while (hi > lo) begin
							mid = (lo + hi) >> 1;
							if (address <= base_tab[mid + 1])
								hi = mid;
							else
								lo = mid + 1;
						end
						if (address >= base_tab[hi] && (address - base_tab[hi]) < size_tab[hi]
								&& !free_tab[hi]) begin
							reply.hit         = 1'b1;
							reply.entry_index = OUT_IDX_W'(hi);
							reply.found_base  = base_tab[hi];
							reply.found_size  = size_tab[hi];
						end
					end
				end
				OP_INSERT: begin
					if (entries >= TABLE_DEPTH) begin
						reply.status = ST_FULL;
					end else begin
						pos = entries;
						while (pos > 0 && base_tab[pos - 1] > address) begin
							base_tab[pos] = base_tab[pos - 1];
							size_tab[pos] = size_tab[pos - 1];
							free_tab[pos] = free_tab[pos - 1];
							pos--;
						end
						base_tab[pos] = address;
						size_tab[pos] = chunk_size;
						free_tab[pos] = chunk_free;
						entries++;
						reply.entry_index = OUT_IDX_W'(pos);
					end
				end
				OP_REMOVE: begin
					idx = int'(entries) - 1;
					while (idx >= 0 && base_tab[idx] != address)
						idx--;
					if (idx < 0) begin
						reply.status = ST_NOT_FOUND;
					end else begin
						for (int k = idx; k + 1 < int'(entries); k++) begin
							base_tab[k] = base_tab[k + 1];
							size_tab[k] = size_tab[k + 1];
							free_tab[k] = free_tab[k + 1];
						end
						entries--;
						reply.entry_index = OUT_IDX_W'(idx);
					end
				end
				default: begin
					sum = '0;
					for (int k = 0; k < int'(entries); k++)
						if (!free_tab[k])
							sum = sum + TOTAL_W'(size_tab[k]);
					reply.used_total = sum;
				end
			endcase
			return reply;
		endfunction

		function void note_request(op_t op, addr_t address, size_t chunk_size,
				logic chunk_free);
			awaited_replies.push_back(apply_table_op(op, address, chunk_size, chunk_free));
		endfunction

		function void check_reply(res_t got);
			res_t want;

			if (awaited_replies.size() == 0) begin
				$error("reply word arrived with no request outstanding");
				errors++;
				return;
			end
			want = awaited_replies.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0h, got %0h", want.hit, got.hit);
				errors++;
			end
			if (got.entry_index !== want.entry_index) begin
				$error("entry_index: expected %0h, got %0h", want.entry_index, got.entry_index);
				errors++;
			end
			if (got.found_base !== want.found_base) begin
				$error("found_base: expected %0h, got %0h", want.found_base, got.found_base);
				errors++;
			end
			if (got.found_size !== want.found_size) begin
				$error("found_size: expected %0h, got %0h", want.found_size, got.found_size);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0h, got %0h", want.status, got.status);
				errors++;
			end
			if (got.used_total !== want.used_total) begin
				$error("used_total: expected %0h, got %0h", want.used_total, got.used_total);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	// Per-phase switches: when one is clear, that side never idles, which gives
	// back-to-back stretches in between the phases with random gaps.
	bit send_idle = 1'b1;
	bit take_idle = 1'b1;

	int unsigned quiet_cycles = 0;

	chunk_table_board board = new();

	scrt_in_if  req_bus ();
	scrt_out_if rsp_bus ();
	scrt_cfg_if cfg_bus ();

	sorted_chunk_range_table_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always #2 clk = ~clk;

	// Offers one request word after a random gap and returns at the edge where
	// it is taken. Valid is left high so that a following word with no gap goes
	// straight out; whoever comes next lowers it if it has to.
	task automatic send_word(op_t op, addr_t address, size_t chunk_size, logic chunk_free);
		int gap;

		gap = send_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.op         <= op;
		req_bus.address    <= address;
		req_bus.chunk_size <= chunk_size;
		req_bus.chunk_free <= chunk_free;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		board.note_request(op, address, chunk_size, chunk_free);
	endtask

	// Waits until every reply is back and the core has settled, then writes the
	// tail limit. The request valid is dropped first so that the last word is
	// not offered a second time while the core sits idle.
	task automatic write_tail_limit(addr_t value);
		req_bus.valid <= 1'b0;
		while (board.awaited_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		board.set_tail_limit(value);
	endtask

	// Picks a lookup address. Most land on the edges or the inside of a chunk
	// that is in the table, so that hits, near misses one past the end and the
	// free-chunk rule all get exercised; the rest are anywhere at all.
	function automatic addr_t chunk_probe_address();
		int unsigned k;
		size_t       span;
		addr_t       offset;

		if (board.entries == 0 || $urandom_range(0, 3) == 0)
			return $urandom;
		k    = $urandom_range(0, board.entries - 1);
		span = board.size_tab[k];
		case ($urandom_range(0, 3))
			0:       offset = '0;
			1:       offset = span - 1;
			2:       offset = span;
			default: offset = (span == 0) ? '0 : $urandom % span;
		endcase
		return board.base_tab[k] + offset;
	endfunction

	// One random operation. Inserts reuse an existing base now and then so that
	// duplicate bases keep turning up, and removes mostly name a base that is
	// present; a table that grows too long is pushed back towards removes to
	// keep the shifting cost per word modest.
	task automatic random_word();
		int unsigned pick;
		addr_t       base;
		size_t       span;

		pick = $urandom_range(0, 99);
		if (board.entries > 150 && pick >= 40 && pick < 70)
			pick = 80;
		if (pick < 40) begin
			send_word(OP_LOOKUP, chunk_probe_address(), $urandom, $urandom_range(0, 1));
		end else if (pick < 70) begin
			case ($urandom_range(0, 4))
				0:       base = (board.entries != 0)
						? board.base_tab[$urandom_range(0, board.entries - 1)] : $urandom;
				1, 2:    base = $urandom;
				default: base = $urandom_range(0, 32'h0010_0000);
			endcase
			case ($urandom_range(0, 19))
				0:       span = '0;
				1, 2, 3: span = $urandom;
				default: span = $urandom_range(1, 32'h4000);
			endcase
			send_word(OP_INSERT, base, span, $urandom_range(0, 3) == 0);
		end else if (pick < 90) begin
			if (board.entries != 0 && $urandom_range(0, 3) != 0)
				base = board.base_tab[$urandom_range(0, board.entries - 1)];
			else
				base = $urandom;
			send_word(OP_REMOVE, base, $urandom, $urandom_range(0, 1));
		end else begin
			send_word(OP_TOTAL, $urandom, $urandom, $urandom_range(0, 1));
		end
	endtask

	// Reply side: ready drops for a random number of cycles before each word,
	// and the word is checked at the edge where it is taken.
	initial begin
		res_t got;
		int   stall;

		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = take_idle ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_bus.valid) @(posedge clk);
			got.hit         = rsp_bus.hit;
			got.entry_index = rsp_bus.entry_index;
			got.found_base  = rsp_bus.found_base;
			got.found_size  = rsp_bus.found_size;
			got.status      = rsp_bus.status;
			got.used_total  = rsp_bus.used_total;
			board.check_reply(got);
		end
	end

	// Watchdog: any accepted word on any channel resets the count.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n             <= 1'b0;
		req_bus.valid      <= 1'b0;
		req_bus.op         <= OP_LOOKUP;
		req_bus.address    <= '0;
		req_bus.chunk_size <= '0;
		req_bus.chunk_free <= 1'b0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.data       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The tail limit is still at its reset value of zero, so
		// nothing can hit until it is raised.
		send_word(OP_LOOKUP, 32'h0000_0010, '0, 1'b0);
		send_word(OP_TOTAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_word(OP_REMOVE, 32'h0000_0000, '0, 1'b0);
		send_word(OP_INSERT, 32'h0000_1000, 32'h0000_0100, 1'b0);
		send_word(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// A second chunk at the same base goes in behind the first one.
		send_word(OP_INSERT, 32'h0000_1000, 32'h0000_0080, 1'b0);
		send_word(OP_INSERT, 32'h0000_2000, 32'h0000_0000, 1'b0);
		send_word(OP_LOOKUP, 32'h0000_1010, '0, 1'b0);

		write_tail_limit(32'hFFFF_FFFF);
		send_word(OP_LOOKUP, 32'h0000_1010, '0, 1'b0);
		send_word(OP_LOOKUP, 32'h0000_107F, '0, 1'b0);
		send_word(OP_LOOKUP, 32'h0000_1080, '0, 1'b0);
		// Not above the first base, then inside the free chunk at address zero.
		send_word(OP_LOOKUP, 32'h0000_0000, '0, 1'b0);
		send_word(OP_LOOKUP, 32'h0000_0005, '0, 1'b0);
		send_word(OP_LOOKUP, 32'h0000_2001, '0, 1'b0);
		send_word(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
		send_word(OP_TOTAL, '0, '0, 1'b0);

		// A limit that cuts through a chunk: the address at the limit hits and
		// the one just above it does not.
		write_tail_limit(32'h0000_1040);
		send_word(OP_LOOKUP, 32'h0000_1040, '0, 1'b0);
		send_word(OP_LOOKUP, 32'h0000_1041, '0, 1'b0);
		// With two equal bases the one with the higher index goes.
		send_word(OP_REMOVE, 32'h0000_1000, '0, 1'b0);
		send_word(OP_REMOVE, 32'h0000_1234, '0, 1'b0);
		send_word(OP_REMOVE, 32'h0000_0000, '0, 1'b0);
		send_word(OP_TOTAL, '0, '0, 1'b0);

		// Random part in four phases, each with its own tail limit and its own
		// mix of idling on the two sides, the last one with none at all.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       write_tail_limit(32'hFFFF_FFFF);
				1:       write_tail_limit($urandom);
				2:       write_tail_limit($urandom_range(32'h0008_0000, 32'h0010_0000));
				default: write_tail_limit(32'hFFFF_FFFE);
			endcase
			send_idle = (phase == 0 || phase == 1);
			take_idle = (phase == 0 || phase == 2);
			repeat (67) random_word();
		end

		req_bus.valid <= 1'b0;
		while (board.awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.awaited_replies.size() != 0) begin
			$error("%0d replies never arrived", board.awaited_replies.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
